[src/hvc_pkg.sv]
// ----------------------------------------------------------------------------
// hvc_pkg
// Shared widths, fixed-point constants and elaboration-time helpers for the
// heliocentric velocity correction pipeline.
// ----------------------------------------------------------------------------
package hvc_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int MJD_W = 33;
  localparam int RA_W  = 25;
  localparam int DEC_W = 24;
  localparam int VEL_W = 23;
  localparam int ANG_W = 32;
  localparam int CV_W  = 33;
  localparam int CZ_W  = 34;
  localparam int PW    = 66;

  localparam logic signed [CV_W-1:0] GAIN_Q30      = 33'sd652032874;
  localparam logic [63:0]            INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam int                     VEL_LIMIT      = 2097152;

  // epoch offset J2000 in MJD, Q(FRACTION_BITS)
  localparam logic [33:0] D0 = 34'(64'd103089 << (FRACTION_BITS - 1));

  localparam logic [63:0] C_ANOM = 64'((((128'd3575277233 << 57) / 128'd3600000000)
                                        + 128'd1) >> 1);
  localparam logic [63:0] C_MLON = 64'((((128'd28046646 << 57) / 128'd36000000)
                                        + 128'd1) >> 1);
  localparam logic [63:0] C_PERI = 64'((((128'd10293735 << 57) / 128'd36000000)
                                        + 128'd1) >> 1);
  localparam logic [31:0] R_ANOM = 32'((((128'd35999050340 << (57 - FRACTION_BITS))
                                        / 128'd13149000000000) + 128'd1) >> 1);
  localparam logic [31:0] R_MLON = 32'((((128'd3600076983 << (57 - FRACTION_BITS))
                                        / 128'd1314900000000) + 128'd1) >> 1);
  localparam logic [31:0] R_PERI = 32'((((128'd171946 << (57 - FRACTION_BITS))
                                        / 128'd1314900000000) + 128'd1) >> 1);

  // phase rounding to Q32 turns folded into the offset
  localparam logic [55:0] C_ANOM_R = 56'(C_ANOM + (64'd1 << 23));
  localparam logic [55:0] C_MLON_R = 56'(C_MLON + (64'd1 << 23));
  localparam logic [55:0] C_PERI_R = 56'(C_PERI + (64'd1 << 23));

  localparam logic [63:0] C_ECC = 64'((((128'd16708634 << 63) / 128'd1000000000)
                                       + 128'd1) >> 1);
  localparam logic [63:0] C_K1  = 64'((((128'd1914602 << 63) / 128'd360000000)
                                       + 128'd1) >> 1);
  localparam logic [16:0] R_ECC = 17'((((128'd42037 << (63 - FRACTION_BITS))
                                       / 128'd36525000000000) + 128'd1) >> 1);
  localparam logic [16:0] R_K1  = 17'((((128'd4817 << (63 - FRACTION_BITS))
                                       / 128'd13149000000000) + 128'd1) >> 1);
  localparam logic [63:0] C_ECC_R = C_ECC + (64'd1 << 31);
  localparam logic [63:0] C_K1_R  = C_K1 + (64'd1 << 31);

  localparam logic [16:0] K2 = 17'((((128'd19993 << 31) / 128'd360000000)
                                    + 128'd1) >> 1);

  localparam logic [39:0] Q_DEG = 40'((((128'd1 << (65 - FRACTION_BITS)) / 128'd360)
                                       + 128'd1) >> 1);

  localparam logic [31:0] OBL_TURN = 32'((((128'd234393 << 33) / 128'd3600000)
                                          + 128'd1) >> 1);

  localparam logic [29:0] V_Q24 = 30'((((128'd297859 << 25) / 128'd10000)
                                       + 128'd1) >> 1);

  // arctan(2^-i) in Q32 turns
  function automatic longint atan_turn(input int i);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [127:0] prod;
    int           k;
    int           e;
    rad = 64'd0;
    for (k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k[0]) begin
          rad = rad - term;
        end else begin
          rad = rad + term;
        end
      end
    end
    prod = 128'(rad) * 128'(INV_TWO_PI_Q64);
    if (i == 0) begin
      return longint'(64'd1 << 29);
    end else begin
      return longint'((prod[127:64] + (64'd1 << 29)) >> 30);
    end
  endfunction

  // sine/cosine of a constant angle, same rotation as the pipelined unit
  function automatic logic [2*CV_W-1:0] sin_cos_const(input logic [31:0] ang,
                                                       input int stages);
    logic        flip;
    logic [31:0] a;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      t;
    int          i;
    flip = ang[31] ^ ang[30];
    a    = ang ^ {flip, 31'd0};
    z    = longint'($signed(a));
    x    = longint'(GAIN_Q30);
    y    = 64'sd0;
    for (i = 0; i < stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      t  = atan_turn(i);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - t;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + t;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    return {CV_W'(y), CV_W'(x)};
  endfunction

  // Q30 product rounded half up
  function automatic logic signed [CV_W-1:0] round30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + (66'sd1 <<< 29)) >>> 30;
    return t[CV_W-1:0];
  endfunction

endpackage

[src/heliocentric_velocity_correction_top.sv]
// Throughput: one transaction per cycle; two CORDIC pipelines in series set the depth.
// busy is held low; out_valid strobes for one cycle per transaction.
// Reset (synchronous, active low) clears all valid flags; data is not reset.
// ----------------------------------------------------------------------------
// heliocentric_velocity_correction_top
// Approximate heliocentric radial-velocity correction from MJD, RA and Dec,
// fully pipelined.
// ----------------------------------------------------------------------------
module heliocentric_velocity_correction_top #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [hvc_pkg::MJD_W-1:0]         in_mjd_q16,
  input  logic [hvc_pkg::RA_W-1:0]          in_ra_q16,
  input  logic signed [hvc_pkg::DEC_W-1:0]  in_dec_q16,
  output logic                              out_valid,
  output logic signed [hvc_pkg::VEL_W-1:0]  out_velocity_q16
);
  import hvc_pkg::*;

  localparam logic [2*CV_W-1:0]      OBL_SC = sin_cos_const(OBL_TURN, CORDIC_STAGES);
  localparam logic signed [CV_W-1:0] SE     = $signed(OBL_SC[2*CV_W-1:CV_W]);
  localparam logic signed [CV_W-1:0] CE     = $signed(OBL_SC[CV_W-1:0]);
  localparam int                     SIDE1_W = 3 * ANG_W;
  localparam int                     SIDE2_W = 4 * CV_W + ANG_W;
  localparam int                     LAT     = 2 * CORDIC_STAGES + 17;
  localparam logic signed [VEL_W-1:0] VEL_MAX = VEL_W'(VEL_LIMIT);
  localparam logic signed [VEL_W-1:0] VEL_MIN = -VEL_W'(VEL_LIMIT);

  // input stage
  logic                    s0_vld_r;
  logic [MJD_W-1:0]        s0_mjd_r;
  logic [RA_W-1:0]         s0_ra_r;
  logic signed [DEC_W-1:0] s0_dec_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_mjd_r <= in_mjd_q16;
    s0_ra_r  <= in_ra_q16;
    s0_dec_r <= in_dec_q16;
  end

  // stage 1: day offset and partial products
  logic signed [33:0] d1;
  logic [16:0]        d1_lo;
  logic signed [16:0] d1_hi;

  logic [48:0]        an_lo_nxt, ml_lo_nxt, pe_lo_nxt;
  logic signed [49:0] an_hi_nxt, ml_hi_nxt, pe_hi_nxt;
  logic signed [51:0] ecc_p_nxt, k1_p_nxt;
  logic [56:0]        ra_lo_nxt;
  logic [32:0]        ra_hi_nxt;
  logic signed [56:0] dec_lo_nxt;
  logic signed [32:0] dec_hi_nxt;

  logic               s1_vld_r;
  logic [48:0]        s1_an_lo_r, s1_ml_lo_r, s1_pe_lo_r;
  logic signed [49:0] s1_an_hi_r, s1_ml_hi_r, s1_pe_hi_r;
  logic signed [51:0] s1_ecc_p_r, s1_k1_p_r;
  logic [56:0]        s1_ra_lo_r;
  logic [32:0]        s1_ra_hi_r;
  logic signed [56:0] s1_dec_lo_r;
  logic signed [32:0] s1_dec_hi_r;

  always_comb begin
    d1    = $signed({1'b0, s0_mjd_r}) - $signed(D0);
    d1_lo = d1[16:0];
    d1_hi = d1[33:17];
    an_lo_nxt  = 49'(d1_lo) * 49'(R_ANOM);
    ml_lo_nxt  = 49'(d1_lo) * 49'(R_MLON);
    pe_lo_nxt  = 49'(d1_lo) * 49'(R_PERI);
    an_hi_nxt  = d1_hi * $signed({1'b0, R_ANOM});
    ml_hi_nxt  = d1_hi * $signed({1'b0, R_MLON});
    pe_hi_nxt  = d1_hi * $signed({1'b0, R_PERI});
    ecc_p_nxt  = d1 * $signed({1'b0, R_ECC});
    k1_p_nxt   = d1 * $signed({1'b0, R_K1});
    ra_lo_nxt  = 57'(s0_ra_r) * 57'(Q_DEG[31:0]);
    ra_hi_nxt  = 33'(s0_ra_r) * 33'(Q_DEG[39:32]);
    dec_lo_nxt = s0_dec_r * $signed({1'b0, Q_DEG[31:0]});
    dec_hi_nxt = s0_dec_r * $signed({1'b0, Q_DEG[39:32]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_an_lo_r  <= an_lo_nxt;
    s1_ml_lo_r  <= ml_lo_nxt;
    s1_pe_lo_r  <= pe_lo_nxt;
    s1_an_hi_r  <= an_hi_nxt;
    s1_ml_hi_r  <= ml_hi_nxt;
    s1_pe_hi_r  <= pe_hi_nxt;
    s1_ecc_p_r  <= ecc_p_nxt;
    s1_k1_p_r   <= k1_p_nxt;
    s1_ra_lo_r  <= ra_lo_nxt;
    s1_ra_hi_r  <= ra_hi_nxt;
    s1_dec_lo_r <= dec_lo_nxt;
    s1_dec_hi_r <= dec_hi_nxt;
  end

  // stage 2: phase sums, rounding to turns
  logic [55:0] an_sum, ml_sum, pe_sum;
  logic [63:0] ecc_sum, k1_sum, ra_sum, dec_sum;

  logic               s2_vld_r;
  logic [ANG_W-1:0]   s2_anom_r, s2_mlon_r, s2_peri_r, s2_ra_r, s2_dec_r;
  logic signed [31:0] s2_ecc_r, s2_k1_r;

  always_comb begin
    an_sum  = C_ANOM_R + (56'(s1_an_hi_r) << 17) + 56'(s1_an_lo_r);
    ml_sum  = C_MLON_R + (56'(s1_ml_hi_r) << 17) + 56'(s1_ml_lo_r);
    pe_sum  = C_PERI_R + (56'(s1_pe_hi_r) << 17) + 56'(s1_pe_lo_r);
    ecc_sum = C_ECC_R - 64'(s1_ecc_p_r);
    k1_sum  = C_K1_R - 64'(s1_k1_p_r);
    ra_sum  = 64'(s1_ra_lo_r) + {s1_ra_hi_r[31:0], 32'd0} + (64'd1 << 31);
    dec_sum = 64'(s1_dec_lo_r) + {s1_dec_hi_r[31:0], 32'd0} + (64'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_anom_r <= an_sum[55:24];
    s2_mlon_r <= ml_sum[55:24];
    s2_peri_r <= pe_sum[55:24];
    s2_ecc_r  <= $signed(ecc_sum[63:32]);
    s2_k1_r   <= $signed(k1_sum[63:32]);
    s2_ra_r   <= ra_sum[63:32];
    s2_dec_r  <= dec_sum[63:32];
  end

  // first CORDIC pass
  logic                   c1_vld;
  logic [SIDE1_W-1:0]     c1_side;
  logic signed [CV_W-1:0] sm, s2a, sp, cp, sa, ca, sd, cd;

  hvc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE1_W)) u_cor_anom (
    .clk(clk), .rst_n(rst_n), .vld_i(s2_vld_r), .ang_i(s2_anom_r),
    .side_i({s2_mlon_r, s2_ecc_r, s2_k1_r}), .vld_o(c1_vld),
    .sin_o(sm), .cos_o(), .side_o(c1_side)
  );
  hvc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cor_anom2 (
    .clk(clk), .rst_n(rst_n), .vld_i(s2_vld_r), .ang_i({s2_anom_r[ANG_W-2:0], 1'b0}),
    .side_i(1'b0), .vld_o(), .sin_o(s2a), .cos_o(), .side_o()
  );
  hvc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cor_peri (
    .clk(clk), .rst_n(rst_n), .vld_i(s2_vld_r), .ang_i(s2_peri_r),
    .side_i(1'b0), .vld_o(), .sin_o(sp), .cos_o(cp), .side_o()
  );
  hvc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cor_ra (
    .clk(clk), .rst_n(rst_n), .vld_i(s2_vld_r), .ang_i(s2_ra_r),
    .side_i(1'b0), .vld_o(), .sin_o(sa), .cos_o(ca), .side_o()
  );
  hvc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cor_dec (
    .clk(clk), .rst_n(rst_n), .vld_i(s2_vld_r), .ang_i(s2_dec_r),
    .side_i(1'b0), .vld_o(), .sin_o(sd), .cos_o(cd), .side_o()
  );

  // stage A: products
  logic                   sa_vld_r;
  logic signed [PW-1:0]   sa_pk1_r, sa_pk2_r, sa_cdca_r, sa_cdsa_r, sa_sdse_r;
  logic [ANG_W-1:0]       sa_mlon_r;
  logic signed [31:0]     sa_ecc_r;
  logic signed [CV_W-1:0] sa_sp_r, sa_cp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else begin
      sa_vld_r <= c1_vld;
    end
  end

  always_ff @(posedge clk) begin
    sa_pk1_r  <= $signed(c1_side[31:0]) * sm;
    sa_pk2_r  <= $signed({1'b0, K2}) * s2a;
    sa_cdca_r <= cd * ca;
    sa_cdsa_r <= cd * sa;
    sa_sdse_r <= sd * SE;
    sa_mlon_r <= c1_side[95:64];
    sa_ecc_r  <= $signed(c1_side[63:32]);
    sa_sp_r   <= sp;
    sa_cp_r   <= cp;
  end

  // stage B: Sun longitude, rounding
  logic signed [PW-1:0] sun_sh;

  logic                   sb_vld_r;
  logic [ANG_W-1:0]       sb_sun_r;
  logic signed [CV_W-1:0] sb_xe_r, sb_t_r, sb_sdse_r, sb_sp_r, sb_cp_r;
  logic signed [31:0]     sb_ecc_r;

  always_comb begin
    sun_sh = (sa_pk1_r + sa_pk2_r + (66'sd1 <<< 27)) >>> 28;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
    end else begin
      sb_vld_r <= sa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sb_sun_r  <= sa_mlon_r + sun_sh[ANG_W-1:0];
    sb_xe_r   <= round30(sa_cdca_r);
    sb_t_r    <= round30(sa_cdsa_r);
    sb_sdse_r <= round30(sa_sdse_r);
    sb_sp_r   <= sa_sp_r;
    sb_cp_r   <= sa_cp_r;
    sb_ecc_r  <= sa_ecc_r;
  end

  // stage C: obliquity rotation product
  logic                   sc_vld_r;
  logic signed [PW-1:0]   sc_tce_r;
  logic [ANG_W-1:0]       sc_sun_r;
  logic signed [CV_W-1:0] sc_xe_r, sc_sdse_r, sc_sp_r, sc_cp_r;
  logic signed [31:0]     sc_ecc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else begin
      sc_vld_r <= sb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sc_tce_r  <= sb_t_r * CE;
    sc_sun_r  <= sb_sun_r;
    sc_xe_r   <= sb_xe_r;
    sc_sdse_r <= sb_sdse_r;
    sc_sp_r   <= sb_sp_r;
    sc_cp_r   <= sb_cp_r;
    sc_ecc_r  <= sb_ecc_r;
  end

  // stage D: ecliptic Y component
  logic                   sd_vld_r;
  logic [ANG_W-1:0]       sd_sun_r;
  logic signed [CV_W-1:0] sd_xe_r, sd_ye_r, sd_sp_r, sd_cp_r;
  logic signed [31:0]     sd_ecc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_vld_r <= 1'b0;
    end else begin
      sd_vld_r <= sc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sd_ye_r  <= round30(sc_tce_r) + sc_sdse_r;
    sd_sun_r <= sc_sun_r;
    sd_xe_r  <= sc_xe_r;
    sd_sp_r  <= sc_sp_r;
    sd_cp_r  <= sc_cp_r;
    sd_ecc_r <= sc_ecc_r;
  end

  // second CORDIC pass: Sun longitude
  logic                   c2_vld;
  logic [SIDE2_W-1:0]     c2_side;
  logic signed [CV_W-1:0] ss, cs;
  logic signed [CV_W-1:0] c2_xe, c2_ye, c2_sp, c2_cp;
  logic signed [31:0]     c2_ecc;

  hvc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE2_W)) u_cor_sun (
    .clk(clk), .rst_n(rst_n), .vld_i(sd_vld_r), .ang_i(sd_sun_r),
    .side_i({sd_xe_r, sd_ye_r, sd_sp_r, sd_cp_r, sd_ecc_r}), .vld_o(c2_vld),
    .sin_o(ss), .cos_o(cs), .side_o(c2_side)
  );

  assign c2_ecc = $signed(c2_side[31:0]);
  assign c2_cp  = $signed(c2_side[32 +: CV_W]);
  assign c2_sp  = $signed(c2_side[32 + CV_W +: CV_W]);
  assign c2_ye  = $signed(c2_side[32 + 2*CV_W +: CV_W]);
  assign c2_xe  = $signed(c2_side[32 + 3*CV_W +: CV_W]);

  // stage E: projection products
  logic                 se_vld_r;
  logic signed [PW-1:0] se_pa_r, se_pb_r, se_pc_r, se_pd_r;
  logic signed [31:0]   se_ecc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_vld_r <= 1'b0;
    end else begin
      se_vld_r <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    se_pa_r  <= ss * c2_xe;
    se_pb_r  <= cs * c2_ye;
    se_pc_r  <= c2_sp * c2_xe;
    se_pd_r  <= c2_cp * c2_ye;
    se_ecc_r <= c2_ecc;
  end

  // stage F: p1, p2
  logic               sf_vld_r;
  logic signed [33:0] sf_p1_r, sf_p2_r;
  logic signed [31:0] sf_ecc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_vld_r <= 1'b0;
    end else begin
      sf_vld_r <= se_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sf_p1_r  <= 34'(round30(se_pa_r)) - 34'(round30(se_pb_r));
    sf_p2_r  <= 34'(round30(se_pc_r)) - 34'(round30(se_pd_r));
    sf_ecc_r <= se_ecc_r;
  end

  // stage G: eccentricity term
  logic                 sg_vld_r;
  logic signed [PW-1:0] sg_pe_r;
  logic signed [33:0]   sg_p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_vld_r <= 1'b0;
    end else begin
      sg_vld_r <= sf_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sg_pe_r <= sf_ecc_r * sf_p2_r;
    sg_p1_r <= sf_p1_r;
  end

  // stage H: total
  logic               sh_vld_r;
  logic signed [34:0] sh_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_vld_r <= 1'b0;
    end else begin
      sh_vld_r <= sg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sh_tot_r <= 35'(sg_p1_r) + 35'(round30(sg_pe_r));
  end

  // stage I: velocity scaling
  logic               si_vld_r;
  logic signed [64:0] si_pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_vld_r <= 1'b0;
    end else begin
      si_vld_r <= sh_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    si_pv_r <= sh_tot_r * $signed({1'b0, V_Q24});
  end

  // stage J: round, negate, saturate
  logic signed [PW-1:0]  v_neg;
  logic signed [VEL_W-1:0] vel_nxt;
  logic                  out_vld_r;
  logic signed [VEL_W-1:0] vel_r;

  always_comb begin
    v_neg = -((66'(si_pv_r) + (66'sd1 <<< (53 - FRACTION_BITS))) >>> (54 - FRACTION_BITS));
    if (v_neg > 66'(VEL_MAX)) begin
      vel_nxt = VEL_MAX;
    end else if (v_neg < 66'(VEL_MIN)) begin
      vel_nxt = VEL_MIN;
    end else begin
      vel_nxt = v_neg[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= si_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    vel_r <= vel_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_velocity_q16 = vel_r;

`ifndef SYNTHESIS
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching transaction");
  a_mid_latency: assert property (@(posedge clk) disable iff (!rst_n)
    c2_vld |-> $past(c1_vld, CORDIC_STAGES + 6))
    else $error("second CORDIC pass out of step");
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_velocity_q16 <= VEL_MAX && out_velocity_q16 >= VEL_MIN))
    else $error("velocity beyond saturation limit");
`endif

endmodule

[src/hvc_cordic.sv]
// ----------------------------------------------------------------------------
// hvc_cordic
// Pipelined rotation-mode CORDIC: sine and cosine of a Q32 turn angle in Q30,
// one iteration per stage, with a side channel carried alongside.
// ----------------------------------------------------------------------------
module hvc_cordic #(
  parameter int STAGES = 24,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  logic [hvc_pkg::ANG_W-1:0]        ang_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             vld_o,
  output logic signed [hvc_pkg::CV_W-1:0]  sin_o,
  output logic signed [hvc_pkg::CV_W-1:0]  cos_o,
  output logic [SIDE_W-1:0]                side_o
);
  import hvc_pkg::*;

  logic                   vld_r  [0:STAGES];
  logic                   flip_r [0:STAGES];
  logic signed [CV_W-1:0] x_r    [0:STAGES];
  logic signed [CV_W-1:0] y_r    [0:STAGES];
  logic signed [CZ_W-1:0] z_r    [0:STAGES];
  logic [SIDE_W-1:0]      side_r [0:STAGES];

  logic                   flip_nxt;
  logic [ANG_W-1:0]       ang_nxt;

  logic                   vld_out_r;
  logic signed [CV_W-1:0] sin_r;
  logic signed [CV_W-1:0] cos_r;
  logic [SIDE_W-1:0]      side_out_r;

  always_comb begin
    flip_nxt = ang_i[ANG_W-1] ^ ang_i[ANG_W-2];
    ang_nxt  = ang_i ^ {flip_nxt, {(ANG_W-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    flip_r[0] <= flip_nxt;
    x_r[0]    <= GAIN_Q30;
    y_r[0]    <= '0;
    z_r[0]    <= CZ_W'($signed(ang_nxt));
    side_r[0] <= side_i;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [CZ_W-1:0] ATAN = CZ_W'(atan_turn(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      flip_r[i+1] <= flip_r[i];
      side_r[i+1] <= side_r[i];
      if (!z_r[i][CZ_W-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else begin
      vld_out_r <= vld_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    side_out_r <= side_r[STAGES];
    if (flip_r[STAGES]) begin
      sin_r <= -y_r[STAGES];
      cos_r <= -x_r[STAGES];
    end else begin
      sin_r <= y_r[STAGES];
      cos_r <= x_r[STAGES];
    end
  end

  assign vld_o  = vld_out_r;
  assign sin_o  = sin_r;
  assign cos_o  = cos_r;
  assign side_o = side_out_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_o |-> $past(vld_i, STAGES + 2))
    else $error("cordic result without matching input");
  a_sin_mag: assert property (@(posedge clk) disable iff (!rst_n)
    vld_o |-> (sin_o[CV_W-1] == sin_o[CV_W-2]))
    else $error("cordic sine out of range");
  a_cos_mag: assert property (@(posedge clk) disable iff (!rst_n)
    vld_o |-> (cos_o[CV_W-1] == cos_o[CV_W-2]))
    else $error("cordic cosine out of range");
`endif

endmodule

[dv/heliocentric_velocity_correction_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heliocentric_velocity_correction_top_tb
// Drives observation transactions (MJD, RA, Dec) into the correction pipeline
// and checks every velocity strobe against an in-bench fixed-point predictor:
// a directed table of extremes and poles, then constrained-range and
// full-width random transactions with random sender gaps.
// ----------------------------------------------------------------------------
module heliocentric_velocity_correction_top_tb;
  import hvc_pkg::*;

  localparam int N_RANDOM  = 1900;
  localparam int STALL_MAX = 2000;
  localparam int DRAIN     = 80;

  typedef struct packed {
    logic [MJD_W-1:0]        mjd;
    logic [RA_W-1:0]         ra;
    logic signed [DEC_W-1:0] dec;
  } obs_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [MJD_W-1:0]         in_mjd_q16;
  logic [RA_W-1:0]          in_ra_q16;
  logic signed [DEC_W-1:0]  in_dec_q16;
  logic                     out_valid;
  logic signed [VEL_W-1:0]  out_velocity_q16;

  logic signed [VEL_W-1:0]  vel_expected_q[$];
  int                       n_errors;
  int                       n_sent;
  int                       n_checked;
  int                       stall_cnt;

  obs_t obs_rows[16] = '{
    '{33'd0,               25'd0,        24'sd0},
    '{33'h1_FFFF_FFFF,     25'd0,        24'sd0},
    '{33'd3377954816,      25'd0,        24'sd0},
    '{33'd3377954816,      25'd23592960, 24'sd0},
    '{33'd3377954816,      25'h1FF_FFFF, 24'sd0},
    '{33'd3377954816,      25'd5898240,  24'sd5898240},
    '{33'd3377954816,      25'd5898240,  -24'sd5898240},
    '{33'd3900000000,      25'd11796480, 24'sd5898240},
    '{33'd3900000000,      25'd11796480, -24'sd5898240},
    '{33'd3900000000,      25'd1000000,  24'sh7F_FFFF},
    '{33'd3900000000,      25'd1000000,  -24'sh80_0000},
    '{33'h1_FFFF_FFFF,     25'h1FF_FFFF, 24'sh7F_FFFF},
    '{33'd0,               25'd17694720, -24'sd1966080},
    '{33'd4200000000,      25'd4915200,  24'sd1500000},
    '{33'd3700000000,      25'd20000000, -24'sd3000000},
    '{33'd1,               25'd1,        -24'sd1}
  };

  heliocentric_velocity_correction_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mjd_q16       (in_mjd_q16),
    .in_ra_q16        (in_ra_q16),
    .in_dec_q16       (in_dec_q16),
    .out_valid        (out_valid),
    .out_velocity_q16 (out_velocity_q16)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round(num * 2^sh / den)
  function automatic logic [63:0] ratio_q(input logic [127:0] num,
                                          input logic [127:0] den, input int sh);
    logic [127:0] t;
    t = (((num << (sh + 1)) / den) + 128'd1) >> 1;
    return t[63:0];
  endfunction

  function automatic longint arctan_turn(input int i);
    logic [63:0]  rad;
    logic [127:0] prod;
    int           k;
    int           e;
    rad = 64'd0;
    if (i == 0) return longint'(64'd1 << 29);
    for (k = 0; k < 40; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        if (k % 2 == 1) rad = rad - (64'd1 << (62 - e)) / 64'(2 * k + 1);
        else rad = rad + (64'd1 << (62 - e)) / 64'(2 * k + 1);
      end
    end
    prod = 128'(rad) * 128'(64'h28BE_60DB_9391_054A);
    return longint'((prod[127:64] + (64'd1 << 29)) >> 30);
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint s, output longint c);
    logic [31:0] q;
    logic        flip;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    int          i;
    q    = ang + 32'h4000_0000;
    flip = q[31];
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'($signed(ang));
    x = 64'sd652032874;
    y = 64'sd0;
    for (i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_turn(i);
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_turn(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic logic [31:0] turn_at(input longint d, input logic [63:0] c0,
                                          input logic [63:0] rate);
    logic [63:0] p;
    p = c0 + 64'(d) * rate + (64'd1 << 23);
    return p[55:24];
  endfunction

  function automatic longint decay_q30(input longint d, input logic [63:0] c0,
                                       input logic [63:0] rate);
    longint v;
    v = longint'(c0) - d * longint'(rate);
    return (v + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic logic [31:0] deg_turn(input logic [63:0] raw);
    logic [63:0] p;
    p = raw * ratio_q(1, 360, 48) + (64'd1 << 31);
    return p[63:32];
  endfunction

  function automatic longint mq30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic predict_velocity(input obs_t o, output logic signed [VEL_W-1:0] vel);
    longint      d;
    logic [31:0] anom;
    logic [31:0] mlon;
    logic [31:0] peri;
    logic [31:0] sun;
    longint      ecc;
    longint      k1;
    longint      k2;
    longint      sm, cm, s2, c2, ss, cs, sp, cp, sa, ca, sd, cd, se, ce;
    longint      xe, ye, tot, v;
    d    = longint'({31'd0, o.mjd}) - (longint'(103089) << 15);
    anom = turn_at(d, ratio_q(64'd3575277233, 64'd3600000000, 56),
                   ratio_q(64'd35999050340, 64'd13149000000000, 40));
    mlon = turn_at(d, ratio_q(28046646, 36000000, 56),
                   ratio_q(64'd3600076983, 64'd1314900000000, 40));
    peri = turn_at(d, ratio_q(10293735, 36000000, 56),
                   ratio_q(171946, 64'd1314900000000, 40));
    ecc  = decay_q30(d, ratio_q(16708634, 1000000000, 62),
                     ratio_q(42037, 64'd36525000000000, 46));
    k1   = decay_q30(d, ratio_q(1914602, 360000000, 62),
                     ratio_q(4817, 64'd13149000000000, 46));
    k2   = longint'(ratio_q(19993, 360000000, 30));
    rotate(anom, sm, cm);
    rotate(anom * 2, s2, c2);
    sun = mlon + 32'((k1 * sm + k2 * s2 + (64'sd1 <<< 27)) >>> 28);
    rotate(sun, ss, cs);
    rotate(peri, sp, cp);
    rotate(deg_turn(64'(o.ra)), sa, ca);
    rotate(deg_turn(64'(longint'(o.dec))), sd, cd);
    rotate(32'(ratio_q(234393, 3600000, 32)), se, ce);
    xe  = mq30(cd, ca);
    ye  = mq30(mq30(cd, sa), ce) + mq30(sd, se);
    tot = (mq30(ss, xe) - mq30(cs, ye)) + mq30(ecc, mq30(sp, xe) - mq30(cp, ye));
    v   = tot * longint'(ratio_q(297859, 10000, 24));
    v   = -((v + (64'sd1 <<< 37)) >>> 38);
    if (v > VEL_LIMIT) v = VEL_LIMIT;
    if (v < -VEL_LIMIT) v = -VEL_LIMIT;
    vel = VEL_W'(v);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] velocity error: %s", $realtime, what);
    n_errors++;
  endtask

  task automatic send_obs(input obs_t o);
    logic signed [VEL_W-1:0] vel;
    in_mjd_q16 <= o.mjd;
    in_ra_q16  <= o.ra;
    in_dec_q16 <= o.dec;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    predict_velocity(o, vel);
    vel_expected_q.push_back(vel);
    n_sent++;
  endtask

  task automatic sender_gap(input bit allow);
    int n;
    if (allow && $urandom_range(99) < 10) begin
      n = $urandom_range(4, 1);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic obs_t random_obs();
    obs_t o;
    if ($urandom_range(99) < 20) begin
      o.mjd = {1'($urandom), 32'($urandom)};
      o.ra  = 25'($urandom);
      o.dec = 24'($urandom);
    end else begin
      o.mjd = (33'($urandom_range(70000, 30000)) << 16) | 33'($urandom_range(65535));
      o.ra  = 25'($urandom_range(23592960));
      o.dec = 24'(int'($urandom_range(11796480)) - 5898240);
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (vel_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction %0d", out_velocity_q16));
        end else begin
          if (out_velocity_q16 !== vel_expected_q[0])
            report_mismatch($sformatf("got %0d exp %0d", out_velocity_q16,
                                      vel_expected_q[0]));
          void'(vel_expected_q.pop_front());
          n_checked++;
        end
      end
      if (out_valid || (start && !busy)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("watchdog: no transaction for %0d cycles", STALL_MAX);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int i;
    n_errors   = 0;
    n_sent     = 0;
    n_checked  = 0;
    stall_cnt  = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_mjd_q16 = '0;
    in_ra_q16  = '0;
    in_dec_q16 = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (obs_rows[r]) begin
      send_obs(obs_rows[r]);
      sender_gap(1'b1);
    end

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 1200) begin
        start <= 1'b0;
        while (vel_expected_q.size() != 0) @(posedge clk);
      end
      send_obs(random_obs());
      sender_gap(i < 500 || i > 900);
    end
    start <= 1'b0;

    while (vel_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d transactions (%0d directed), %0d results checked",
             n_sent, $size(obs_rows), n_checked);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
